// File: design/brfr_pkg.sv
// Shared types and constants for the byte ring FIFO with rewind.
// No dependencies; imported by every module of the block.
package brfr_pkg;

    localparam int DEPTH   = 1024;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int SUM_W   = ADDR_W + 1;
    localparam int LEVEL_W = 11;

    localparam logic [1:0] ACT_WRITE  = 2'd0;
    localparam logic [1:0] ACT_READ   = 2'd1;
    localparam logic [1:0] ACT_MARK   = 2'd2;
    localparam logic [1:0] ACT_REWIND = 2'd3;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] wr_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0]         rd_byte;
        logic               done_res;
        logic [LEVEL_W-1:0] level;
        logic [LEVEL_W-1:0] space;
    } t_out_item;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    typedef struct packed {
        logic               done_res;
        logic               is_read;
        logic [LEVEL_W-1:0] level;
        logic [LEVEL_W-1:0] space;
    } t_step_res;

endpackage

// File: design/brfr_store.sv
// Byte storage array of the ring FIFO, one write and one registered read port.
// Depends on brfr_pkg for the depth and the request struct.
module brfr_store
    import brfr_pkg::*;
(
    input  logic     i_clk,
    input  t_mem_req i_req,
    output logic [7:0] o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rd_data <= r_mem[i_req.raddr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: design/brfr_ctrl.sv
// Read position, fill count and mark registers of the ring FIFO.
// Depends on brfr_pkg; drives the storage request and the per-transaction status.
module brfr_ctrl
    import brfr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_accept,
    input  t_in_item  i_item,
    output t_mem_req  o_req,
    output t_step_res o_res
);

    logic [ADDR_W-1:0] r_head, n_head;
    logic [CNT_W-1:0]  r_fill, n_fill;
    logic [ADDR_W-1:0] r_saved_head;
    logic [CNT_W-1:0]  r_saved_fill;

    logic              full;
    logic              empty;
    logic [SUM_W-1:0]  wsum;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] head_inc;
    logic              moved;
    logic [CNT_W:0]    space_full;

    assign full  = (r_fill == CNT_W'(DEPTH));
    assign empty = (r_fill == '0);
    assign wsum  = SUM_W'(r_head) + SUM_W'(r_fill);
    assign waddr = (wsum >= SUM_W'(DEPTH)) ? ADDR_W'(wsum - SUM_W'(DEPTH)) : ADDR_W'(wsum);
    assign head_inc = (r_head == ADDR_W'(DEPTH - 1)) ? '0 : r_head + ADDR_W'(1);

    always_comb begin
        n_head = r_head;
        n_fill = r_fill;
        moved  = 1'b0;
        unique case (i_item.action)
            ACT_WRITE: begin
                if (!full) begin
                    n_fill = r_fill + CNT_W'(1);
                    moved  = 1'b1;
                end
            end
            ACT_READ: begin
                if (!empty) begin
                    n_head = head_inc;
                    n_fill = r_fill - CNT_W'(1);
                    moved  = 1'b1;
                end
            end
            ACT_MARK: begin
            end
            ACT_REWIND: begin
                n_head = r_saved_head;
                n_fill = r_saved_fill;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head       <= '0;
            r_fill       <= '0;
            r_saved_head <= '0;
            r_saved_fill <= '0;
        end else if (i_accept) begin
            r_head <= n_head;
            r_fill <= n_fill;
            if (i_item.action == ACT_MARK) begin
                r_saved_head <= r_head;
                r_saved_fill <= r_fill;
            end
        end
    end

    assign space_full = (CNT_W + 1)'(DEPTH) - (CNT_W + 1)'(n_fill);

    assign o_req.we    = i_accept && (i_item.action == ACT_WRITE) && !full;
    assign o_req.waddr = waddr;
    assign o_req.wdata = i_item.wr_byte;
    assign o_req.re    = i_accept && (i_item.action == ACT_READ) && !empty;
    assign o_req.raddr = r_head;

    assign o_res.done_res = moved;
    assign o_res.is_read  = (i_item.action == ACT_READ);
    assign o_res.level    = LEVEL_W'(32'(n_fill));
    assign o_res.space    = LEVEL_W'(32'(space_full));

endmodule

// File: design/byte_ring_fifo_with_rewind_top.sv
// Top level of the byte ring FIFO with mark and rewind: handshakes and result register.
// Depends on brfr_pkg, brfr_ctrl and brfr_store.
//
//   channel | direction | handshake                | payload
//   in      | input     | i_in_valid / o_in_ready  | i_in_item  (t_in_item)
//   out     | output    | o_out_valid / i_out_ready| o_out_item (t_out_item)
//
// One transaction per cycle unless the output stalls; its result appears
// in the cycle after acceptance, read through the registered store port.
// Reset clears positions, count and mark; store contents stay undefined.
// A stalled result holds; input is taken again as soon as the result register frees.
module byte_ring_fifo_with_rewind_top
    import brfr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    logic      accept;
    t_mem_req  req;
    t_step_res res;
    logic [7:0] rd_data;

    logic      r_out_valid;
    t_step_res r_res;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    brfr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_in_item),
        .o_req    (req),
        .o_res    (res)
    );

    brfr_store u_store (
        .i_clk     (i_clk),
        .i_req     (req),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= res;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_out_item.rd_byte  = (r_res.done_res && r_res.is_read) ? rd_data : 8'd0;
    assign o_out_item.done_res = r_res.done_res;
    assign o_out_item.level    = r_res.level;
    assign o_out_item.space    = r_res.space;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_out_item.level) + 32'(o_out_item.space)) == 32'(DEPTH) % 2048)
        else $error("level and space do not add up to the depth");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.done_res |-> o_out_item.rd_byte == 8'd0)
        else $error("nonzero byte on a transaction that moved nothing");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in_item.action == ACT_MARK |=> !$past(req.we) && !$past(req.re))
        else $error("storage access on a mark");

    assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule
